>>> design/hmmd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmmd_pkg
// Shared types and constants for the handheld memory map decoder.
// ----------------------------------------------------------------------------
package hmmd_pkg;

   localparam int BANK_BITS     = 5;
   localparam int ADDR_BITS     = 16;
   localparam int ROM_SIZE_BITS = 20;
   localparam int BOOT_SIZE_BITS = 9;
   localparam int EXT_BITS      = 19;
   localparam int MAIN_DEPTH    = 16384;
   localparam int MAIN_AW       = $clog2(MAIN_DEPTH);
   localparam int PAGE_DEPTH    = 512;
   localparam int PAGE_AW       = $clog2(PAGE_DEPTH);
   localparam int CSR_INDEX_BITS = 1;

   localparam logic [ROM_SIZE_BITS-1:0]  ROM_BYTES_RESET  = 20'd32768;
   localparam logic [BOOT_SIZE_BITS-1:0] BOOT_BYTES_RESET = 9'd256;
   localparam logic [BANK_BITS-1:0]      BANK_RESET       = 5'd1;

   localparam logic [ADDR_BITS-1:0] ADDR_BOOT_OFF = 16'hFF50;
   localparam logic [ADDR_BITS-1:0] ADDR_SERIAL   = 16'hFF02;
   localparam logic [7:0]           SERIAL_START  = 8'h81;
   localparam logic [7:0]           FILL_OPEN     = 8'hFF;
   localparam logic [7:0]           FILL_ZERO     = 8'h00;
   // I/O byte 1 and 2 within the high page store
   localparam logic [PAGE_AW-1:0]   PAGE_SERIAL_DATA = 9'h101;
   localparam logic [PAGE_AW-1:0]   PAGE_SERIAL_CTRL = 9'h102;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROM_BYTES  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BOOT_BYTES = 1'b1;

   localparam logic [1:0] SRC_INTERNAL = 2'd0;
   localparam logic [1:0] SRC_CART     = 2'd1;
   localparam logic [1:0] SRC_BOOT     = 2'd2;

   localparam logic KIND_READ  = 1'b0;
   localparam logic KIND_WRITE = 1'b1;

   typedef enum logic [1:0] {
      SEL_FILL,
      SEL_MAIN,
      SEL_PAGE
   } sel_type;

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

   // What one beat does to the stores and what its result will hold
   typedef struct packed {
      logic                 main_we;
      logic [MAIN_AW-1:0]   main_addr;
      logic                 page_we;
      logic [PAGE_AW-1:0]   page_wr_addr;
      logic [7:0]           page_wr_data;
      logic [PAGE_AW-1:0]   page_rd_addr;
      logic                 bank_we;
      logic [BANK_BITS-1:0] bank_value;
      logic                 overlay_clear;
      sel_type              sel;
      logic [7:0]           fill;
      logic [1:0]           source;
      logic [EXT_BITS-1:0]  ext_addr;
      logic                 serial;
   } decode_type;

   typedef struct packed {
      sel_type             sel;
      logic [7:0]          fill;
      logic [1:0]          source;
      logic [EXT_BITS-1:0] ext_addr;
      logic                serial;
   } pend_type;

endpackage

>>> design/hmmd_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmmd_req_if
// Bus access channel: one read or write per beat.
// ----------------------------------------------------------------------------
interface hmmd_req_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [15:0] address;
   logic [7:0]  write_byte;

   modport source (output valid, output kind, output address, output write_byte,
                   input ready);
   modport sink (input valid, input kind, input address, input write_byte,
                 output ready);
endinterface

>>> design/hmmd_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmmd_rsp_if
// Result channel: one beat for every bus access.
// ----------------------------------------------------------------------------
interface hmmd_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  read_byte;
   logic [1:0]  data_source;
   logic [18:0] external_address;
   logic        serial_valid;
   logic [7:0]  serial_byte;

   modport source (output valid, output read_byte, output data_source,
                   output external_address, output serial_valid, output serial_byte,
                   input ready);
   modport sink (input valid, input read_byte, input data_source,
                 input external_address, input serial_valid, input serial_byte,
                 output ready);
endinterface

>>> design/hmmd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmmd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hmmd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

>>> design/hmmd_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmmd_decode
// Address decode of one bus access: store selects, register updates and the
// external ROM address of the result.
// ----------------------------------------------------------------------------
module hmmd_decode (
   input  logic                               kind,
   input  logic [15:0]                        address,
   input  logic [7:0]                         write_byte,
   input  logic [hmmd_pkg::ROM_SIZE_BITS-1:0] rom_bytes,
   input  logic [hmmd_pkg::BOOT_SIZE_BITS-1:0] boot_bytes,
   input  logic [hmmd_pkg::BANK_BITS-1:0]     bank,
   input  logic                               overlay,
   output hmmd_pkg::decode_type               dec
);
   import hmmd_pkg::*;

   logic                 live;
   logic [EXT_BITS-1:0]  banked;
   logic [BANK_BITS-1:0] bank_low;

   assign live     = overlay && (boot_bytes != '0);
   assign banked   = {bank, address[13:0]};
   assign bank_low = write_byte[BANK_BITS-1:0];

   always_comb begin
      dec              = '0;
      dec.sel          = SEL_FILL;
      dec.fill         = FILL_ZERO;
      dec.source       = SRC_INTERNAL;
      dec.main_addr    = {address >= 16'hC000, address[12:0]};
      dec.page_wr_addr = address[PAGE_AW-1:0];
      dec.page_rd_addr = address[PAGE_AW-1:0];
      dec.page_wr_data = write_byte;
      dec.bank_value   = (bank_low == '0) ? BANK_RESET : bank_low;

      if (kind == KIND_READ) begin
         dec.fill = FILL_OPEN;
         if (live && address < 16'h0100) begin
            dec.fill = FILL_ZERO;
            if ({1'b0, address[7:0]} < boot_bytes) begin
               dec.source   = SRC_BOOT;
               dec.ext_addr = {11'd0, address[7:0]};
            end
         end else begin
            case (address) inside
               [16'h0000:16'h3FFF]: begin
                  if ({6'd0, address[13:0]} < rom_bytes) begin
                     dec.source   = SRC_CART;
                     dec.ext_addr = {5'd0, address[13:0]};
                     dec.fill     = FILL_ZERO;
                  end
               end
               [16'h4000:16'h7FFF]: begin
                  if ({1'b0, banked} < rom_bytes) begin
                     dec.source   = SRC_CART;
                     dec.ext_addr = banked;
                     dec.fill     = FILL_ZERO;
                  end
               end
               [16'h8000:16'h9FFF], [16'hC000:16'hFDFF]: dec.sel = SEL_MAIN;
               [16'hFE00:16'hFE9F], [16'hFF00:16'hFFFE]: dec.sel = SEL_PAGE;
               default: dec.sel = SEL_FILL;
            endcase
         end
      end else begin
         if (address == ADDR_BOOT_OFF && live && write_byte != '0) begin
            // switch-off beat is not stored
            dec.overlay_clear = 1'b1;
         end else begin
            case (address) inside
               [16'h2000:16'h3FFF]: dec.bank_we = 1'b1;
               [16'h8000:16'h9FFF], [16'hC000:16'hFDFF]: dec.main_we = 1'b1;
               [16'hFE00:16'hFE9F], [16'hFF00:16'hFFFE]: begin
                  dec.page_we = 1'b1;
                  if (address == ADDR_SERIAL && write_byte == SERIAL_START) begin
                     // emit I/O byte 1, leave the control byte cleared
                     dec.serial       = 1'b1;
                     dec.page_wr_addr = PAGE_SERIAL_CTRL;
                     dec.page_wr_data = FILL_ZERO;
                     dec.page_rd_addr = PAGE_SERIAL_DATA;
                  end
               end
               default: dec.page_we = 1'b0;
            endcase
         end
      end
   end
endmodule

>>> design/handheld_memory_map_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// handheld_memory_map_decoder_core
// Bus memory map decoder with internal video, work and high-page stores.
// ----------------------------------------------------------------------------
// Each bus access is accepted and decoded, and its store access goes to RAM in
// that cycle; the RAM's registered read returns the data in the next cycle,
// when the result is loaded into the output register. One access is in flight
// at a time, so the block takes no new beat until the last result is loaded
// and the output side can take it. Video and work RAM share one 16K-byte RAM;
// sprite table, I/O and high RAM share one 512-byte RAM. Neither is cleared
// after reset. Cartridge ROM and boot ROM reads come back as an external
// address with source set; the user must write the configuration registers
// only while no access is outstanding, and the block does not enforce it.
// ----------------------------------------------------------------------------
module handheld_memory_map_decoder_core (
   input  logic                                  clock,
   input  logic                                  reset,
   hmmd_req_if.sink                              req_bus,
   hmmd_rsp_if.source                            rsp_bus,
   input  logic                                  csr_write_enable,
   input  logic [hmmd_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [hmmd_pkg::ROM_SIZE_BITS-1:0]    csr_data
);
   import hmmd_pkg::*;

   state_type state_ff, state_in;

   logic [ROM_SIZE_BITS-1:0]  rom_bytes_ff;
   logic [BOOT_SIZE_BITS-1:0] boot_bytes_ff;
   logic [BANK_BITS-1:0]      bank_ff;
   logic                      overlay_ff;

   pend_type pend_ff;
   logic     out_valid_ff, out_valid_in;
   logic [7:0]          out_byte_ff;
   logic [1:0]          out_source_ff;
   logic [EXT_BITS-1:0] out_ext_ff;
   logic                out_serial_ff;
   logic [7:0]          out_serial_byte_ff;

   decode_type dec;
   logic       accept;
   logic       load_out;
   logic [7:0] main_q;
   logic [7:0] page_q;
   logic [7:0] data_sel;

   hmmd_decode u_decode (
      .kind       (req_bus.kind),
      .address    (req_bus.address),
      .write_byte (req_bus.write_byte),
      .rom_bytes  (rom_bytes_ff),
      .boot_bytes (boot_bytes_ff),
      .bank       (bank_ff),
      .overlay    (overlay_ff),
      .dec        (dec)
   );

   hmmd_ram #(.WIDTH(8), .DEPTH(MAIN_DEPTH)) u_main_ram (
      .clock   (clock),
      .wr_en   (accept && dec.main_we),
      .wr_addr (dec.main_addr),
      .wr_data (req_bus.write_byte),
      .rd_addr (dec.main_addr),
      .rd_data (main_q)
   );

   hmmd_ram #(.WIDTH(8), .DEPTH(PAGE_DEPTH)) u_page_ram (
      .clock   (clock),
      .wr_en   (accept && dec.page_we),
      .wr_addr (dec.page_wr_addr),
      .wr_data (dec.page_wr_data),
      .rd_addr (dec.page_rd_addr),
      .rd_data (page_q)
   );

   // the output register is free by the time the pending result lands
   assign req_bus.ready = (state_ff == ST_IDLE) && (!out_valid_ff || rsp_bus.ready);
   assign accept        = req_bus.valid && req_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      load_out = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            load_out = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      case (pend_ff.sel)
         SEL_MAIN: data_sel = main_q;
         SEL_PAGE: data_sel = page_q;
         default:  data_sel = pend_ff.fill;
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (rsp_bus.valid && rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
      if (load_out) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rom_bytes_ff  <= ROM_BYTES_RESET;
         boot_bytes_ff <= BOOT_BYTES_RESET;
         bank_ff       <= BANK_RESET;
         overlay_ff    <= 1'b1;
         out_valid_ff  <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_ROM_BYTES:  rom_bytes_ff  <= csr_data;
               CSR_BOOT_BYTES: boot_bytes_ff <= csr_data[BOOT_SIZE_BITS-1:0];
               default:        rom_bytes_ff  <= rom_bytes_ff;
            endcase
         end
         if (accept && dec.bank_we) begin
            bank_ff <= dec.bank_value;
         end
         if (accept && dec.overlay_clear) begin
            overlay_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pend_ff.sel      <= dec.sel;
         pend_ff.fill     <= dec.fill;
         pend_ff.source   <= dec.source;
         pend_ff.ext_addr <= dec.ext_addr;
         pend_ff.serial   <= dec.serial;
      end
      if (load_out) begin
         out_byte_ff        <= data_sel;
         out_source_ff      <= pend_ff.source;
         out_ext_ff         <= pend_ff.ext_addr;
         out_serial_ff      <= pend_ff.serial;
         out_serial_byte_ff <= pend_ff.serial ? page_q : FILL_ZERO;
      end
   end

   assign rsp_bus.valid            = out_valid_ff;
   assign rsp_bus.read_byte        = out_byte_ff;
   assign rsp_bus.data_source      = out_source_ff;
   assign rsp_bus.external_address = out_ext_ff;
   assign rsp_bus.serial_valid     = out_serial_ff;
   assign rsp_bus.serial_byte      = out_serial_byte_ff;
endmodule
